@@ rtl/lms_pkg.sv @@
// Shared constants and types for the LED multiplex scan selector.
// No dependencies; imported by every module of the block.
package lms_pkg;

	localparam int LED_COUNT_DEF = 18;
	localparam int MASK_W        = 18;
	localparam int IDX_W         = 5;
	localparam int LVL_W         = 8;
	localparam int CNT_W         = 5;
	localparam int CFG_W         = 5;
	localparam int IN_DATA_W     = 24;
	localparam int OUT_DATA_W    = 32;

	localparam logic FUNC_FILL = 1'b0;
	localparam logic FUNC_SCAN = 1'b1;

	localparam logic [CFG_W-1:0] LEDS_AT_ONCE_RST = 5'd1;

	// one accepted command handed to the walker
	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] end_index;
		logic             lit;
	} cmd_t;

	// one scan result
	typedef struct packed {
		logic [MASK_W-1:0] on_mask;
		logic [CNT_W-1:0]  on_count;
		logic [IDX_W-1:0]  next_start;
	} res_t;

endpackage

@@ rtl/led_multiplex_scan_select.sv @@
// Top level of the LED multiplex scan selector: stream ports, config register,
// output register. Depends on lms_pkg and lms_walk.
//
// Usage: the slave stream takes command words. tuser[0] selects the kind:
// a fill writes the lit state (level nonzero) into LEDs first_index up to
// end_index (exclusive, both clamped to the LED count); a scan tick walks the
// LEDs circularly from the start pointer and selects up to leds_at_once lit
// ones (zero means no limit). A fill yields no output word; a scan yields one
// master word with the on-mask, the count and the new start pointer.
// The config channel writes leds_at_once; write it only while the block is idle.
//
// Timing: one walker visits one LED per cycle, but a scan holds its last
// step while the output register is full. A fill visits LEDs first up to
// end; an empty fill leaves the walker idle. A scan visits N LEDs (1..LED_COUNT);
// its word reaches the master side through the output register.
// tready stays low while the walker runs.
// Stalls: a finished word waits in the output register while the next command
// is taken; a second scan holds its last step until that register frees up.
// Reset clears all lit flags, the pointer to LED 0 and leds_at_once to 1.
module led_multiplex_scan_select
	import lms_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [4:0] first_index, [9:5] end_index, [17:10] level, [23:18] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [0] func
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [17:0] on_mask, [22:18] on_count, [27:23] next_start, [31:28] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [CFG_W-1:0] leds_at_once_q;
	logic             out_valid_q;
	res_t             out_res_q;

	cmd_t cmd;
	logic busy;
	logic start;
	logic res_ready;
	logic res_valid;
	res_t res;

	// unpack the command word; a fill only needs to know lit or dark
	always_comb begin
		cmd.func        = s_tuser;
		cmd.first_index = s_tdata[IDX_W-1:0];
		cmd.end_index   = s_tdata[2*IDX_W-1:IDX_W];
		cmd.lit         = (s_tdata[2*IDX_W+LVL_W-1:2*IDX_W] != '0);
	end

	assign s_tready  = !busy;
	assign start     = s_tvalid && s_tready;
	assign res_ready = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	lms_walk #(
		.LED_COUNT (LED_COUNT)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.leds_at_once (leds_at_once_q),
		.res_ready    (res_ready),
		.busy         (busy),
		.res_valid    (res_valid),
		.res          (res)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leds_at_once_q <= LEDS_AT_ONCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			leds_at_once_q <= cfg_data;
		end
	end

	// output register: load a finished scan, drop the word once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - MASK_W - CNT_W - IDX_W)'(0),
		out_res_q.next_start, out_res_q.on_count, out_res_q.on_mask};

endmodule

@@ rtl/lms_walk.sv @@
// Lit-flag store and the one-LED-per-cycle walker for fills and scans; a scan holds its last step until res_ready.
// Depends on lms_pkg.
module lms_walk
	import lms_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cmd_t             cmd,
	input  logic [CFG_W-1:0] leds_at_once,
	input  logic             res_ready,
	output logic             busy,
	output logic             res_valid,
	output res_t             res
);

	localparam int PW  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int IWC = $clog2(LED_COUNT + 1);
	localparam int IW  = (IWC > IDX_W) ? IWC : IDX_W;
	localparam int CW  = $clog2(LED_COUNT + 2);
	localparam int LW  = (CW > CFG_W) ? CW : CFG_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]           state_q;
	logic [LED_COUNT-1:0] flags_q;
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        origin_q;
	logic [PW-1:0]        scan_start_q;
	logic [IW-1:0]        hi_q;
	logic                 lit_q;
	logic [CW-1:0]        taken_q;
	logic [MASK_W-1:0]    mask_q;

	logic [IW-1:0]     lo_c;
	logic [IW-1:0]     hi_c;
	logic [PW-1:0]     origin_c;
	logic              hit;
	logic [CW-1:0]     taken_n;
	logic [MASK_W-1:0] mask_n;
	logic [PW-1:0]     pos_n;
	logic [LW-1:0]     limit;
	logic              scan_done;
	logic              fill_done;

	// clamp the fill range to the LED count and wrap an out-of-range scan start to 0
	always_comb begin
		lo_c = (32'(cmd.first_index) > LED_COUNT) ? IW'(LED_COUNT) : IW'(cmd.first_index);
		hi_c = (32'(cmd.end_index) > LED_COUNT) ? IW'(LED_COUNT) : IW'(cmd.end_index);
		origin_c = (32'(scan_start_q) >= LED_COUNT) ? '0 : scan_start_q;
	end

	// shared step: look at one flag, advance the pointer
	always_comb begin
		hit     = flags_q[pos_q];
		taken_n = taken_q + CW'(hit);
		for (int b = 0; b < MASK_W; b++) begin
			mask_n[b] = mask_q[b] | (hit && (32'(pos_q) == b));
		end
		pos_n     = (32'(pos_q) == LED_COUNT - 1) ? '0 : pos_q + PW'(1);
		limit     = (leds_at_once == '0) ? LW'(LED_COUNT + 1) : LW'(leds_at_once);
		scan_done = (pos_n == origin_q) || (LW'(taken_n) >= limit);
		fill_done = (IW'(pos_q) + IW'(1)) >= hi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			flags_q      <= '0;
			scan_start_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (cmd.func == FUNC_SCAN) begin
							state_q <= ST_SCAN;
						end else if (lo_c < hi_c) begin
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					flags_q[pos_q] <= lit_q;
					if (fill_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_done && res_ready) begin
						scan_start_q <= pos_n;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walker datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			taken_q <= '0;
			mask_q  <= '0;
			lit_q   <= cmd.lit;
			hi_q    <= hi_c;
			if (cmd.func == FUNC_SCAN) begin
				pos_q    <= origin_c;
				origin_q <= origin_c;
			end else begin
				pos_q <= PW'(lo_c);
			end
		end else if (state_q == ST_FILL) begin
			pos_q <= pos_n;
		end else if (state_q == ST_SCAN && !scan_done) begin
			pos_q   <= pos_n;
			taken_q <= taken_n;
			mask_q  <= mask_n;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_SCAN) && scan_done && res_ready;

	always_comb begin
		res.on_mask    = mask_n;
		res.on_count   = (32'(taken_n) > 31) ? CNT_W'(31) : CNT_W'(taken_n);
		res.next_start = IDX_W'(pos_n);
	end

endmodule

@@ rtl/lms_chk.sv @@
// Port-level checker for the LED multiplex scan selector, bound to the top.
// Depends on lms_pkg.
module lms_chk
	import lms_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// a held result word stays up
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// the count matches the mask when every LED has a mask bit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (LED_COUNT > MASK_W) ||
			($countones(m_tdata[MASK_W-1:0]) == 32'(m_tdata[MASK_W+CNT_W-1:MASK_W])))
		else $error("on_count disagrees with on_mask");

	// the pointer stays inside the LED range when LED_COUNT is at most 32
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (LED_COUNT > 32) ||
			(32'(m_tdata[MASK_W+CNT_W+IDX_W-1:MASK_W+CNT_W]) < LED_COUNT))
		else $error("next_start out of range");

	// a fill never produces a word
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == FUNC_FILL) && !m_tvalid |=> !m_tvalid)
		else $error("fill produced an output word");

	// a scan keeps the block busy for at least its first step
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == FUNC_SCAN) |=> !s_tready)
		else $error("scan accepted without walking");

endmodule

bind led_multiplex_scan_select lms_chk #(
	.LED_COUNT (LED_COUNT)
) u_lms_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
